[hw/rtl/svptw_pkg.sv]
`default_nettype none

package svptw_pkg;

  localparam int unsigned DEF_TABLE_PAGES  = 8;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned SLOT_W           = 9;
  localparam int unsigned PPN_W            = 44;
  localparam int unsigned VPN_W            = 27;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic FUNC_WRITE = 1'b0;

  localparam logic [1:0] CFG_ROOT = 2'd0;
  localparam logic [1:0] CFG_BASE = 2'd1;
  localparam logic [1:0] CFG_USER = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ABOVE_LIMIT = 3'd1;
  localparam logic [2:0] ST_NO_TABLE    = 3'd2;
  localparam logic [2:0] ST_LEAF_INVAL  = 3'd3;
  localparam logic [2:0] ST_NOT_USER    = 3'd4;
  localparam logic [2:0] ST_OUTSIDE     = 3'd5;

  typedef struct packed {
    logic        func;
    logic [11:0] word_index;
    logic [63:0] word_value;
    logic [38:0] vaddr;
  } in_item_t;

  typedef struct packed {
    logic [55:0] paddr;
    logic [9:0]  leaf_flags;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [PPN_W-1:0] root_page_number;
    logic [PPN_W-1:0] store_base_page;
    logic             require_user;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_NOP   = 2'd1,
    CMD_LIMIT = 2'd2,
    CMD_WALK  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [11:0]      word_index;
    logic [63:0]      word_value;
    logic [VPN_W-1:0] vpn;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/svptw_front.sv]
`default_nettype none

module svptw_front #(
  parameter int unsigned TABLE_PAGES = svptw_pkg::DEF_TABLE_PAGES
) (
  input  wire                  in_valid,
  output logic                 in_stall,
  input  svptw_pkg::in_item_t  in_item,
  input  wire                  clearing,
  input  svptw_pkg::q_stat_t   q_stat,
  output logic                 push,
  output svptw_pkg::cmd_t      cmd
);
  import svptw_pkg::*;

  localparam int unsigned STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;

  logic in_range;

  assign in_range = {20'd0, in_item.word_index} < 32'(STORE_WORDS);
  assign in_stall = clearing || q_stat.full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    cmd.word_index = in_item.word_index;
    cmd.word_value = in_item.word_value;
    cmd.vpn        = in_item.vaddr[38:12];
    if (in_item.func == FUNC_WRITE) begin
      cmd.kind = in_range ? CMD_WRITE : CMD_NOP;
    end else begin
      cmd.kind = in_item.vaddr[38] ? CMD_LIMIT : CMD_WALK;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/svptw_queue.sv]
`default_nettype none

module svptw_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  svptw_pkg::cmd_t     push_cmd,
  input  wire                 pop,
  output svptw_pkg::cmd_t     pop_cmd,
  output svptw_pkg::q_stat_t  q_stat
);
  import svptw_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign pop_cmd      = q_r[rd_ptr_r];
  assign q_stat.full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = count_r == '0;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/svptw_back.sv]
`default_nettype none

module svptw_back #(
  parameter int unsigned TABLE_PAGES = svptw_pkg::DEF_TABLE_PAGES
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  svptw_pkg::cfg_t      cfg,
  input  svptw_pkg::q_stat_t   q_stat,
  input  svptw_pkg::cmd_t      cmd,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  wire                  out_stall,
  output svptw_pkg::out_item_t out_item
);
  import svptw_pkg::*;

  localparam int unsigned STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned PG_W        = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned ADDR_W      = PG_W + SLOT_W;

  localparam logic [1:0] LVL_ROOT = 2'd2;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        level_r, level_nxt;
  logic [VPN_W-1:0]  vpn_r, vpn_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [63:0]       mem [STORE_WORDS];
  logic [63:0]       rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [63:0]       mem_wd;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic              out_free;
  logic              load_out;
  out_item_t         res;
  logic [PPN_W-1:0]  next_page;

  function automatic logic page_ok(input logic [PPN_W-1:0] page,
                                   input logic [PPN_W-1:0] base);
    logic [PPN_W-1:0] diff;
    diff = page - base;
    return (page >= base) && (diff < PPN_W'(TABLE_PAGES));
  endfunction

  function automatic logic [ADDR_W-1:0] word_addr(input logic [PPN_W-1:0] page,
                                                  input logic [PPN_W-1:0] base,
                                                  input logic [SLOT_W-1:0] slot);
    logic [PPN_W-1:0] diff;
    diff = page - base;
    return {diff[PG_W-1:0], slot};
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [VPN_W-1:0] vpn,
                                                input logic [1:0] level);
    logic [SLOT_W-1:0] s;
    case (level)
      LVL_ROOT: s = vpn[26:18];
      LVL_MID:  s = vpn[17:9];
      default:  s = vpn[8:0];
    endcase
    return s;
  endfunction

  assign clearing  = state_r == S_CLEAR;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign next_page = rdata_r[53:10];

  always_comb begin
    state_nxt   = state_r;
    level_nxt   = level_r;
    vpn_nxt     = vpn_r;
    clr_cnt_nxt = clr_cnt_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    load_out    = 1'b0;
    res         = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(STORE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty && out_free) begin
          pop = 1'b1;
          case (cmd.kind)
            CMD_WRITE: begin
              mem_we   = 1'b1;
              mem_wa   = ADDR_W'(cmd.word_index);
              mem_wd   = cmd.word_value;
              load_out = 1'b1;
            end
            CMD_LIMIT: begin
              res.status = ST_ABOVE_LIMIT;
              load_out   = 1'b1;
            end
            CMD_WALK: begin
              if (!page_ok(cfg.root_page_number, cfg.store_base_page)) begin
                res.status = ST_OUTSIDE;
                load_out   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = word_addr(cfg.root_page_number, cfg.store_base_page,
                                      slot_of(cmd.vpn, LVL_ROOT));
                level_nxt = LVL_ROOT;
                vpn_nxt   = cmd.vpn;
                state_nxt = S_WAIT;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_WAIT: begin
        if (level_r != LVL_LEAF) begin
          if (!rdata_r[0]) begin
            res.status = ST_NO_TABLE;
            load_out   = 1'b1;
            state_nxt  = S_IDLE;
          end else if (!page_ok(next_page, cfg.store_base_page)) begin
            res.status = ST_OUTSIDE;
            load_out   = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = word_addr(next_page, cfg.store_base_page,
                                  slot_of(vpn_r, level_r - 1'b1));
            level_nxt = level_r - 1'b1;
          end
        end else begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          if (!rdata_r[0]) begin
            res.status = ST_LEAF_INVAL;
          end else if (cfg.require_user && !rdata_r[4]) begin
            res.status = ST_NOT_USER;
          end else begin
            res.paddr      = {next_page, 12'd0};
            res.leaf_flags = rdata_r[9:0];
            res.status     = ST_OK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_item_nxt  = res;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      level_r     <= LVL_ROOT;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vpn_r      <= vpn_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sv39_page_table_walker.sv]
// A write or an immediate fault goes through the command queue to the output register;
// a full walk first reads the table at the root, middle and leaf levels in turn.
// Throughput: one write per cycle while the output is not stalled; a walk keeps the
// back end busy, taking no new command until its three dependent reads of the
// single-port table store are done. Reset: registers take their reset values, then
// a clearing pass zeroes the TABLE_PAGES * 512 store words, with in_stall held high.
`default_nettype none

module sv39_page_table_walker #(
  parameter int unsigned TABLE_PAGES = svptw_pkg::DEF_TABLE_PAGES
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  svptw_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output svptw_pkg::out_item_t out_item,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [43:0]           cfg_wdata
);
  import svptw_pkg::*;

  cfg_t    cfg_r;
  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    push;
  logic    pop;
  logic    clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.root_page_number <= '0;
      cfg_r.store_base_page  <= '0;
      cfg_r.require_user     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT: cfg_r.root_page_number <= cfg_wdata;
        CFG_BASE: cfg_r.store_base_page  <= cfg_wdata;
        CFG_USER: cfg_r.require_user     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  svptw_front #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .clearing (clearing),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  svptw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  svptw_back #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .cmd       (pop_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
